// ===== design/text_console_writer_assert.svh =====
// assertion macros for the text console writer modules
// expects aclk and aresetn in the scope of each use
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_IMP(lbl, ante, cons, msg)
`define TCW_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/tcw_pkg.sv =====
// shared constants, codes and controller/datapath interface types
// for the text console writer; no dependencies
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;
    localparam int CROW_OUT_W = 5;
    localparam int CCOL_OUT_W = 7;

    localparam logic [15:0] BLANK_CELL   = 16'h0720;
    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [7:0]  CHAR_LOW     = 8'd32;
    localparam logic [7:0]  CHAR_HIGH    = 8'd126;
    localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
    localparam logic [7:0]  COLOR_RESET  = 8'h07;

    typedef enum logic [1:0] {
        REQ_PUT_CURSOR = 2'd0,
        REQ_PUT_AT     = 2'd1,
        REQ_CLEAR      = 2'd2,
        REQ_READ       = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic sweep_blank;
        logic sweep_clear;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        req_t req;
        logic scroll;
        logic sweep_row_last;
        logic sweep_all_last;
        logic out_valid;
    } dp_stat_t;

endpackage

// ===== design/tcw_datapath.sv =====
// cell store, cursor, scroll pointer, item and result registers
// depends on tcw_pkg and text_console_writer_assert.svh
`include "text_console_writer_assert.svh"

module tcw_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [31:0]               s_tdata,   // char_code, cell_color, column, row
    input  logic [1:0]                s_tuser,   // req_type
    input  logic                      cfg_valid,
    input  logic [7:0]                cfg_data,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [31:0]               m_tdata,   // status, cell_data, cursor_row_now,
                                                 // cursor_column_now
    input  tcw_pkg::dp_cmd_t          cmd,
    output tcw_pkg::dp_stat_t         stat
);
    import tcw_pkg::*;

    localparam int RS_W = ROW_W + 1;

    logic [15:0]       mem [CELLS];
    logic [15:0]       rd_data_reg;

    req_t              req_reg;
    logic [7:0]        ch_reg;
    logic [7:0]        color_reg;
    logic [6:0]        col_reg;
    logic [5:0]        row_reg;

    logic [7:0]        text_color_reg;
    logic [ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0] sweep_reg;
    status_t           status_reg, status_next;
    logic              read_hit_reg;
    logic              out_valid_reg;
    logic [31:0]       out_data_reg;

    logic              in_range, printable, newline, wrap, scroll;
    logic [COL_W:0]    col_inc;
    logic              exec_wr, exec_rd;
    logic [15:0]       exec_wdata;

    logic [ROW_W-1:0]  addr_row;
    logic [COL_W-1:0]  addr_col;
    logic [RS_W-1:0]   row_sum, phys_row;
    logic [ADDR_W-1:0] map_addr, mem_addr;
    logic              wr_en, rd_en;
    logic [15:0]       wr_data;

    // request decode
    always_comb begin
        in_range  = ({1'b0, col_reg} < 8'(COLUMNS)) && ({1'b0, row_reg} < 7'(ROWS));
        printable = (ch_reg >= CHAR_LOW) && (ch_reg <= CHAR_HIGH);
        newline   = (ch_reg == CHAR_NEWLINE);
        col_inc   = {1'b0, cursor_col_reg} + 1'b1;
        wrap      = newline || (col_inc == (COL_W+1)'(COLUMNS));
        scroll    = 1'b0;
        exec_wr   = 1'b0;
        exec_rd   = 1'b0;
        exec_wdata = {color_reg, ch_reg};
        status_next = ST_OK;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        top_next  = top_reg;
        unique case (req_reg)
            REQ_PUT_CURSOR: begin
                exec_wdata = {text_color_reg, ch_reg};
                exec_wr    = !newline && printable;
                if (!newline && !printable) begin
                    status_next = ST_REJECT;
                end
                if (wrap) begin
                    cursor_col_next = '0;
                    if (cursor_row_reg == ROW_W'(ROWS - 1)) begin
                        scroll = 1'b1;
                        top_next = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    end else begin
                        cursor_row_next = cursor_row_reg + 1'b1;
                    end
                end else begin
                    cursor_col_next = col_inc[COL_W-1:0];
                end
            end
            REQ_PUT_AT: begin
                if (!in_range) begin
                    status_next = ST_RANGE;
                end else if (!printable) begin
                    status_next = ST_REJECT;
                end else begin
                    exec_wr = 1'b1;
                end
            end
            REQ_CLEAR: begin
                status_next = ST_OK;
            end
            REQ_READ: begin
                if (!in_range) begin
                    status_next = ST_RANGE;
                end else begin
                    exec_rd = 1'b1;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // logical row to physical row through the rotating top pointer
    always_comb begin
        if (cmd.sweep_blank) begin
            addr_row = ROW_W'(ROWS - 1);
            addr_col = sweep_reg[COL_W-1:0];
        end else if (req_reg == REQ_PUT_CURSOR) begin
            addr_row = cursor_row_reg;
            addr_col = cursor_col_reg;
        end else begin
            addr_row = row_reg[ROW_W-1:0];
            addr_col = col_reg[COL_W-1:0];
        end
        row_sum  = RS_W'(addr_row) + RS_W'(top_reg);
        phys_row = (row_sum >= RS_W'(ROWS)) ? row_sum - RS_W'(ROWS) : row_sum;
        map_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(addr_col);
        mem_addr = cmd.sweep_clear ? sweep_reg : map_addr;
        wr_en    = cmd.sweep_clear || cmd.sweep_blank || (cmd.exec && exec_wr);
        rd_en    = cmd.exec && exec_rd;
        if (cmd.sweep_clear) begin
            wr_data = BLANK_CELL;
        end else if (cmd.sweep_blank) begin
            wr_data = {text_color_reg, CHAR_SPACE};
        end else begin
            wr_data = exec_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[mem_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= req_t'(s_tuser);
            ch_reg    <= s_tdata[7:0];
            color_reg <= s_tdata[15:8];
            col_reg   <= s_tdata[22:16];
            row_reg   <= s_tdata[28:23];
        end
        if (cmd.exec) begin
            status_reg   <= status_next;
            read_hit_reg <= exec_rd;
        end
        if (cmd.load_out) begin
            out_data_reg <= {2'b00,
                             CCOL_OUT_W'(cursor_col_reg),
                             CROW_OUT_W'(cursor_row_reg),
                             read_hit_reg ? rd_data_reg : 16'h0000,
                             status_reg};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= COLOR_RESET;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            top_reg        <= '0;
            sweep_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                text_color_reg <= cfg_data;
            end
            if (cmd.exec) begin
                cursor_row_reg <= cursor_row_next;
                cursor_col_reg <= cursor_col_next;
                top_reg        <= top_next;
            end
            if (cmd.capture) begin
                sweep_reg <= '0;
            end else if (cmd.sweep_blank || cmd.sweep_clear) begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign stat.req            = req_reg;
    assign stat.scroll         = scroll;
    assign stat.sweep_row_last = (sweep_reg == ADDR_W'(COLUMNS - 1));
    assign stat.sweep_all_last = (sweep_reg == ADDR_W'(CELLS - 1));
    assign stat.out_valid      = out_valid_reg;

    `TCW_ASSERT(a_cursor_col_range, cursor_col_reg <= COL_W'(COLUMNS - 1), "cursor column past last column")
    `TCW_ASSERT(a_rows_range, (cursor_row_reg <= ROW_W'(ROWS - 1)) && (top_reg <= ROW_W'(ROWS - 1)), "cursor row or top row out of range")
    `TCW_ASSERT_NXT(a_load_shows, cmd.load_out, m_tvalid, "loaded result not presented")

endmodule

// ===== design/tcw_ctrl.sv =====
// sequencing state machine: accept, execute, row blank and clear sweeps, result
// depends on tcw_pkg and text_console_writer_assert.svh
`include "text_console_writer_assert.svh"

module tcw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                m_tready,
    input  logic                m_tvalid,
    input  tcw_pkg::dp_stat_t   stat,
    output tcw_pkg::dp_cmd_t    cmd
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_BLANK,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_free;

    assign out_free = !stat.out_valid || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                cmd.sweep_clear = 1'b1;
                if (stat.sweep_all_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.req == REQ_CLEAR) begin
                    state_next = S_CLEAR;
                end else if (stat.scroll) begin
                    state_next = S_BLANK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_BLANK: begin
                cmd.sweep_blank = 1'b1;
                if (stat.sweep_row_last) begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR: begin
                cmd.sweep_clear = 1'b1;
                if (stat.sweep_all_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    `TCW_ASSERT_NXT(a_accept_exec, s_tvalid && s_tready, state_reg == S_EXEC, "accepted item not executed")
    `TCW_ASSERT_NXT(a_exec_next, state_reg == S_EXEC, (state_reg == S_DONE) || (state_reg == S_BLANK) || (state_reg == S_CLEAR), "bad state after execute")
    `TCW_ASSERT_IMP(a_no_overwrite, cmd.load_out, !m_tvalid || m_tready, "result loaded over a waiting one")

endmodule

// ===== design/text_console_writer.sv =====
// top level of the text console writer: controller plus datapath
// depends on tcw_pkg, tcw_ctrl and tcw_datapath

// Text console over an 80 x 25 store of 16-bit cells (attribute high byte, character low
// byte) in one single-port memory. Each item gives exactly one result. A put or a read
// passes through accept, memory access and the result register in turn; a put
// at the cursor that moves past the last row blanks a row before its result, since scrolling
// only advances a rotating top-row pointer and then blanks the new bottom row one cell per
// cycle in text_color. A clear writes every cell, one per cycle. After reset the same
// clearing pass runs with s_tready low; cfg writes are taken at any time and must be made
// while no item is in flight. The next item is accepted while a result still waits on the
// output register.
module text_console_writer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code[7:0], cell_color[15:8], column[22:16],
                                   // row[28:23], zero[31:29]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[1:0], cell_data[17:2], cursor_row_now[22:18],
                                   // cursor_column_now[29:23], zero[31:30]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // text_color
);
    import tcw_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== tb/sv/text_console_writer_test.sv =====
// self-checking test of text_console_writer: directed, scroll, backpressure and random
// traffic, checked against a cycle-free console model kept in this file
// depends on tcw_pkg and text_console_writer
module text_console_writer_test;
    import tcw_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] cell_data;
        logic [4:0]  cursor_row_now;
        logic [6:0]  cursor_column_now;
    } console_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // char_code[7:0], cell_color[15:8], column[22:16],
                                   // row[28:23], zero[31:29]
    logic [1:0]  s_tuser   = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // status[1:0], cell_data[17:2], cursor_row_now[22:18],
                                   // cursor_column_now[29:23], zero[31:30]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;   // text_color

    // console model
    logic [15:0] screen_model [CELLS] = '{default: BLANK_CELL};
    int          cur_row = 0;
    int          cur_col = 0;
    logic [7:0]  text_color_reg = COLOR_RESET;

    console_result_t pending_results[$];
    int          err_count = 0;
    int unsigned cycle_count = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int          hold_cycles = 0;

    text_console_writer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic bit is_printable(logic [7:0] ch);
        return ch >= CHAR_LOW && ch <= CHAR_HIGH;
    endfunction

    function automatic void advance_row();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < COLUMNS * (ROWS - 1); i++)
                screen_model[i] = screen_model[i + COLUMNS];
            for (int i = COLUMNS * (ROWS - 1); i < CELLS; i++)
                screen_model[i] = {text_color_reg, CHAR_SPACE};
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic console_result_t compute_console_result(req_t req, logic [7:0] ch,
            logic [7:0] attr, logic [6:0] col, logic [5:0] row);
        console_result_t res;
        bit in_range;
        int idx;
        res = '0;
        res.status = ST_OK;
        in_range = (int'(col) < COLUMNS) && (int'(row) < ROWS);
        idx = int'(row) * COLUMNS + int'(col);
        case (req)
            REQ_PUT_CURSOR: begin
                if (ch == CHAR_NEWLINE) begin
                    advance_row();
                end else begin
                    if (is_printable(ch))
                        screen_model[cur_row * COLUMNS + cur_col] = {text_color_reg, ch};
                    else
                        res.status = ST_REJECT;
                    cur_col++;
                    if (cur_col >= COLUMNS)
                        advance_row();
                end
            end
            REQ_PUT_AT: begin
                if (!in_range)
                    res.status = ST_RANGE;
                else if (!is_printable(ch))
                    res.status = ST_REJECT;
                else
                    screen_model[idx] = {attr, ch};
            end
            REQ_CLEAR: begin
                foreach (screen_model[i])
                    screen_model[i] = BLANK_CELL;
            end
            REQ_READ: begin
                if (!in_range)
                    res.status = ST_RANGE;
                else
                    res.cell_data = screen_model[idx];
            end
        endcase
        res.cursor_row_now = cur_row[4:0];
        res.cursor_column_now = cur_col[6:0];
        return res;
    endfunction

    task automatic send_item(req_t req, int ch, int attr, int col, int row);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, row[5:0], col[6:0], attr[7:0], ch[7:0]};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(
            compute_console_result(req, ch[7:0], attr[7:0], col[6:0], row[5:0]));
    endtask

    task automatic put_cursor(int ch);
        send_item(REQ_PUT_CURSOR, ch, $urandom_range(0, 255), $urandom_range(0, 127),
                  $urandom_range(0, 63));
    endtask

    task automatic read_cell(int col, int row);
        send_item(REQ_READ, $urandom_range(0, 255), $urandom_range(0, 255), col, row);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_text_color(int value);
        cfg_valid <= 1'b1;
        cfg_data  <= value[7:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        text_color_reg = value[7:0];
    endtask

    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, want, got);
            err_count++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin : result_check
        console_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item: expected none actual %h", $time, m_tdata);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_tdata[1:0]);
                check_field("cell_data", want.cell_data, m_tdata[17:2]);
                check_field("cursor_row_now", want.cursor_row_now, m_tdata[22:18]);
                check_field("cursor_column_now", want.cursor_column_now, m_tdata[29:23]);
            end
        end
    end

    // result receiver with random stalls and requested long holds
    initial begin : result_sink
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            stall = rx_idle ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && hold_cycles == 0);
        end
    end

    task automatic test_directed_cases();
        write_text_color(8'h1E);
        read_cell(0, 0);
        read_cell(COLUMNS - 1, ROWS - 1);
        read_cell(COLUMNS, 0);
        read_cell(0, ROWS);
        read_cell(127, 63);
        send_item(REQ_PUT_AT, CHAR_SPACE, 8'h00, 0, 0);
        send_item(REQ_PUT_AT, CHAR_HIGH, 8'hFF, COLUMNS - 1, ROWS - 1);
        send_item(REQ_PUT_AT, CHAR_LOW - 1, 8'h5A, 5, 3);
        send_item(REQ_PUT_AT, CHAR_HIGH + 1, 8'hA5, 5, 3);
        send_item(REQ_PUT_AT, CHAR_NEWLINE, 8'h3C, 5, 3);
        // range is checked before the character
        send_item(REQ_PUT_AT, 8'hFF, 8'h11, COLUMNS, ROWS - 1);
        send_item(REQ_PUT_AT, 8'h41, 8'h22, 0, 63);
        put_cursor(8'h48);
        put_cursor(8'h00);
        put_cursor(8'hFF);
        put_cursor(CHAR_NEWLINE);
        read_cell(0, 0);
        read_cell(1, 0);
        read_cell(COLUMNS - 1, ROWS - 1);
        read_cell(5, 3);
        send_item(REQ_CLEAR, 8'h41, 8'hFF, 127, 63);
        read_cell(0, 0);
        read_cell(COLUMNS - 1, ROWS - 1);
        put_cursor(CHAR_HIGH);
    endtask

    task automatic test_wrap_and_scroll();
        int i;
        int ch;
        wait_idle();
        write_text_color(8'hFF);
        for (i = 0; i < ROWS + 5; i++)
            put_cursor(CHAR_NEWLINE);
        for (i = 0; i < COLUMNS + 5; i++) begin
            // rejected character in the last column still wraps and scrolls
            if (i == COLUMNS - 1)
                ch = CHAR_HIGH + 1;
            else if ($urandom_range(0, 9) == 0)
                ch = $urandom_range(CHAR_NEWLINE + 1, CHAR_LOW - 1);
            else
                ch = $urandom_range(CHAR_LOW, CHAR_HIGH);
            put_cursor(ch);
        end
        for (i = 0; i < 8; i++)
            read_cell($urandom_range(0, COLUMNS - 1), ROWS - 1 - (i % 2));
        wait_idle();
        write_text_color(8'h00);
        put_cursor(CHAR_NEWLINE);
        put_cursor(CHAR_NEWLINE);
        for (i = 0; i < 6; i++)
            read_cell($urandom_range(0, COLUMNS - 1), ROWS - 1 - (i % 3));
    endtask

    task automatic test_input_backpressure();
        int i;
        wait_idle();
        tx_idle = 1'b0;
        hold_cycles = 300;
        for (i = 0; i < 20; i++) begin
            if (i % 2 == 0)
                put_cursor($urandom_range(CHAR_LOW, CHAR_HIGH));
            else
                read_cell(cur_col > 0 ? cur_col - 1 : 0, cur_row);
        end
        tx_idle = 1'b1;
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        int draw;
        int ch;
        int col;
        int row;
        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            write_text_color($urandom_range(0, 255));
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            for (n = 0; n < 56; n++) begin
                draw = $urandom_range(0, 99);
                if ($urandom_range(0, 6) == 0)
                    ch = $urandom_range(0, 255);
                else
                    ch = $urandom_range(CHAR_LOW, CHAR_HIGH);
                if ($urandom_range(0, 6) == 0) begin
                    col = $urandom_range(0, 127);
                    row = $urandom_range(0, 63);
                end else if ($urandom_range(0, 1) == 0) begin
                    col = $urandom_range(0, COLUMNS - 1);
                    row = $urandom_range(0, ROWS - 1);
                end else begin
                    // near the cursor, where most text lands
                    col = $urandom_range(0, COLUMNS - 1);
                    row = (cur_row > 0 && $urandom_range(0, 1) == 1) ? cur_row - 1 : cur_row;
                end
                if (draw < 45) begin
                    if ($urandom_range(0, 9) == 0)
                        ch = CHAR_NEWLINE;
                    put_cursor(ch);
                end else if (draw < 65) begin
                    send_item(REQ_PUT_AT, ch, $urandom_range(0, 255), col, row);
                end else if (draw < 98) begin
                    read_cell(col, row);
                end else begin
                    send_item(REQ_CLEAR, ch, $urandom_range(0, 255), col, row);
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_wrap_and_scroll();
        test_input_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (CELLS + 100) @(posedge aclk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
